// File: design/mrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrb_pkg
// Shared widths and controller states for the base-2 strong probable-prime test.
// ----------------------------------------------------------------------------
package mrb_pkg;

  localparam int NUM_BITS = 32;
  localparam int CNT_W    = $clog2(NUM_BITS);
  localparam int CAND_W   = 32;
  localparam int ODD_W    = 32;
  localparam int EXP_W    = 5;

  typedef logic [NUM_BITS-1:0] word_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SPLIT,
    S_SQ,
    S_DBL,
    S_TEST,
    S_EMIT
  } state_t;

endpackage

// File: design/mrb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrb_if
// Valid/ready channels for the candidate request and the test result.
// ----------------------------------------------------------------------------
interface mrb_in_if import mrb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CAND_W-1:0] candidate;

  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

interface mrb_out_if import mrb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             probable_prime;
  logic [ODD_W-1:0] odd_part;
  logic [EXP_W-1:0] twos_exponent;

  modport source (output valid, output probable_prime, output odd_part,
                  output twos_exponent, input ready);
  modport sink   (input valid, input probable_prime, input odd_part,
                  input twos_exponent, output ready);
endinterface

// File: design/miller_rabin_base_two_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// miller_rabin_base_two_test
// Strong probable-prime test to base 2 with a bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one candidate per request; it is taken only while the
//   controller is idle, so one test runs at a time. out_ch carries one result
//   per request: probable_prime, odd part m and exponent k of n-1 = m*2^k.
//   Zero, one and even candidates go straight to the emit state. An odd
//   candidate first strips the trailing zeros of n-1, then forms 2^m mod n
//   by left-to-right exponentiation over all NUM_BITS exponent bits: each
//   bit is one modular squaring plus one doubling step. Up to k-1 further
//   squarings follow. The shift-and-add squaring unit handles one multiplier
//   bit per cycle.
//   The result sits in an output register; a new request is taken while it
//   waits. If the sink stalls, a finished second result waits in the
//   controller until the register frees up.
//   Synchronous active-low reset returns the controller to idle and drops
//   out_ch.valid.
// ----------------------------------------------------------------------------
module miller_rabin_base_two_test import mrb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  mrb_in_if.sink    in_ch,
  mrb_out_if.source out_ch
);

  state_t state_r, state_nxt;

  word_t n_r,   n_nxt;
  word_t m_r,   m_nxt;
  word_t e_r,   e_nxt;
  word_t x_r,   x_nxt;
  word_t acc_r, acc_nxt;
  word_t b_r,   b_nxt;
  cnt_t  k_r,   k_nxt;
  cnt_t  rem_r, rem_nxt;
  cnt_t  cnt_r, cnt_nxt;
  cnt_t  ecnt_r, ecnt_nxt;
  logic  loop_r, loop_nxt;
  logic  prime_r, prime_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_prime_r, out_prime_nxt;
  logic [ODD_W-1:0] out_odd_r,   out_odd_nxt;
  logic [EXP_W-1:0] out_exp_r,   out_exp_nxt;

  localparam cnt_t LAST = CNT_W'(NUM_BITS - 1);

  word_t cand_n;
  logic  in_fire;
  logic  out_free;
  logic  trivial;
  logic  sq_done;
  logic  exp_done;
  logic  hit;

  // shared modular step: (2*acc + add) mod n, inputs below n
  word_t                step_acc;
  word_t                step_add;
  logic [NUM_BITS+1:0]  step_sum;
  logic [NUM_BITS+1:0]  step_n1;
  logic [NUM_BITS+1:0]  step_n2;
  word_t                step_out;

  assign cand_n   = NUM_BITS'(in_ch.candidate);
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign trivial  = (cand_n < NUM_BITS'(3)) || !cand_n[0];
  assign sq_done  = (cnt_r == LAST);
  assign exp_done = (ecnt_r == LAST);
  assign hit      = (x_r == n_r - NUM_BITS'(1)) || (!loop_r && x_r == NUM_BITS'(1));

  assign in_ch.ready = (state_r == S_IDLE);

  assign out_ch.valid          = out_valid_r;
  assign out_ch.probable_prime = out_prime_r;
  assign out_ch.odd_part       = out_odd_r;
  assign out_ch.twos_exponent  = out_exp_r;

  always_comb begin
    step_acc = (state_r == S_SQ) ? acc_r : x_r;
    step_add = (state_r == S_SQ && b_r[NUM_BITS-1]) ? x_r : '0;
    step_sum = ({2'b00, step_acc} << 1) + {2'b00, step_add};
    step_n1  = {2'b00, n_r};
    step_n2  = {1'b0, n_r, 1'b0};
    if (step_sum >= step_n2) begin
      step_out = NUM_BITS'(step_sum - step_n2);
    end else if (step_sum >= step_n1) begin
      step_out = NUM_BITS'(step_sum - step_n1);
    end else begin
      step_out = NUM_BITS'(step_sum);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = trivial ? S_EMIT : S_SPLIT;
      end
      S_SPLIT: begin
        if (m_r[0]) state_nxt = S_SQ;
      end
      S_SQ: begin
        if (sq_done) state_nxt = loop_r ? S_TEST : S_DBL;
      end
      S_DBL: begin
        state_nxt = exp_done ? S_TEST : S_SQ;
      end
      S_TEST: begin
        if (hit || rem_r == '0) state_nxt = S_EMIT;
        else                    state_nxt = S_SQ;
      end
      S_EMIT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and output register
  always_comb begin
    n_nxt     = n_r;
    m_nxt     = m_r;
    e_nxt     = e_r;
    x_nxt     = x_r;
    acc_nxt   = acc_r;
    b_nxt     = b_r;
    k_nxt     = k_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    ecnt_nxt  = ecnt_r;
    loop_nxt  = loop_r;
    prime_nxt = prime_r;

    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_prime_nxt = out_prime_r;
    out_odd_nxt   = out_odd_r;
    out_exp_nxt   = out_exp_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          n_nxt     = cand_n;
          m_nxt     = trivial ? '0 : cand_n - NUM_BITS'(1);
          k_nxt     = '0;
          prime_nxt = (cand_n == NUM_BITS'(2));
        end
      end
      S_SPLIT: begin
        if (!m_r[0]) begin
          m_nxt = m_r >> 1;
          k_nxt = k_r + CNT_W'(1);
        end else begin
          e_nxt    = m_r;
          ecnt_nxt = '0;
          x_nxt    = NUM_BITS'(1);
          acc_nxt  = '0;
          b_nxt    = NUM_BITS'(1);
          cnt_nxt  = '0;
          loop_nxt = 1'b0;
          rem_nxt  = k_r - CNT_W'(1);
        end
      end
      S_SQ: begin
        acc_nxt = step_out;
        b_nxt   = b_r << 1;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (sq_done) x_nxt = step_out;
      end
      S_DBL: begin
        // multiply by the base when the exponent bit is set
        if (e_r[NUM_BITS-1]) x_nxt = step_out;
        e_nxt    = e_r << 1;
        ecnt_nxt = ecnt_r + CNT_W'(1);
        acc_nxt  = '0;
        b_nxt    = e_r[NUM_BITS-1] ? step_out : x_r;
        cnt_nxt  = '0;
      end
      S_TEST: begin
        if (hit) begin
          prime_nxt = 1'b1;
        end else if (rem_r == '0) begin
          prime_nxt = 1'b0;
        end else begin
          rem_nxt  = rem_r - CNT_W'(1);
          loop_nxt = 1'b1;
          acc_nxt  = '0;
          b_nxt    = x_r;
          cnt_nxt  = '0;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_prime_nxt = prime_r;
          out_odd_nxt   = ODD_W'(m_r);
          out_exp_nxt   = EXP_W'(k_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    m_r         <= m_nxt;
    e_r         <= e_nxt;
    x_r         <= x_nxt;
    acc_r       <= acc_nxt;
    b_r         <= b_nxt;
    k_r         <= k_nxt;
    rem_r       <= rem_nxt;
    cnt_r       <= cnt_nxt;
    ecnt_r      <= ecnt_nxt;
    loop_r      <= loop_nxt;
    prime_r     <= prime_nxt;
    out_prime_r <= out_prime_nxt;
    out_odd_r   <= out_odd_nxt;
    out_exp_r   <= out_exp_nxt;
  end

  // a new result only ever comes from the emit state
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result raised outside emit state");

  // modular residues stay reduced while squaring
  a_residue_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQ) |-> (x_r < n_r) && (acc_r < n_r))
    else $error("residue not reduced modulo n");

  // a nonzero odd part is odd and comes with a nonzero exponent
  a_odd_part: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_odd_r != '0) |-> (out_odd_r[0] && out_exp_r != '0))
    else $error("odd part or exponent malformed");

  // a held probable_prime flag and odd part do not change while the sink stalls
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> $stable(out_prime_r) && $stable(out_odd_r))
    else $error("pending result changed");

endmodule
